FILE: hdl/atrlf_pkg.sv
`default_nettype none
package atrlf_pkg;

  localparam int LINE_MAX = 64;
  localparam int FILL_W   = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = $clog2(LINE_MAX);

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;

  localparam int ECHO_LEN = 8;
  localparam int SCAN_LEN = 7;

  // "AT+CWLAP"
  localparam logic [7:0] ECHO_PREFIX [ECHO_LEN] = '{
    8'h41, 8'h54, 8'h2b, 8'h43, 8'h57, 8'h4c, 8'h41, 8'h50
  };
  // "+CWLAP:"
  localparam logic [7:0] SCAN_PREFIX [SCAN_LEN] = '{
    8'h2b, 8'h43, 8'h57, 8'h4c, 8'h41, 8'h50, 8'h3a
  };

  // Decision for one received word, handed from the line state logic to the line store.
  typedef struct packed {
    logic              store;
    logic              forward;
    logic [ADDR_W-1:0] addr;
    logic [FILL_W-1:0] len;
  } decision_t;

endpackage
`default_nettype wire

FILE: hdl/atrlf_in_if.sv
`default_nettype none
interface atrlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/atrlf_out_if.sv
`default_nettype none
interface atrlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_last;

  modport source (output valid, output line_byte, output line_last, input ready);
  modport sink (input valid, input line_byte, input line_last, output ready);
endinterface
`default_nettype wire

FILE: hdl/atrlf_track.sv
`default_nettype none
module atrlf_track (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata,
  output atrlf_pkg::decision_t      dec
);

  logic [atrlf_pkg::FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [7:0] scan_cnt_r, scan_cnt_nxt;
  logic [7:0] max_lines_r;
  logic       echo_ok_r, echo_ok_nxt;
  logic       scan_ok_r, scan_ok_nxt;
  logic       prev_cr_r;

  logic ignore, early_lf, store, complete, echo_m, scan_m, drop;
  logic echo_base, scan_base;

  always_comb begin
    fill_inc  = fill_r + atrlf_pkg::FILL_W'(1);
    ignore    = (fill_r == '0) && (rx_byte == atrlf_pkg::CHAR_NUL);
    early_lf  = (rx_byte == atrlf_pkg::CHAR_LF) && (fill_r < atrlf_pkg::FILL_W'(2));
    store     = !ignore && !early_lf;
    // With fewer than two words held an LF is an early LF, so prev_cr_r
    // always refers to the word just before this one.
    complete  = store && (rx_byte == atrlf_pkg::CHAR_LF) && prev_cr_r;

    // The prefix flags cover the positions written so far in this line.
    echo_base = (fill_r == '0) ? 1'b1 : echo_ok_r;
    scan_base = (fill_r == '0) ? 1'b1 : scan_ok_r;
    echo_ok_nxt = echo_base &&
      ((fill_r >= atrlf_pkg::FILL_W'(atrlf_pkg::ECHO_LEN)) ||
       (rx_byte == atrlf_pkg::ECHO_PREFIX[fill_r[2:0]]));
    scan_ok_nxt = scan_base &&
      ((fill_r >= atrlf_pkg::FILL_W'(atrlf_pkg::SCAN_LEN)) ||
       (rx_byte == atrlf_pkg::SCAN_PREFIX[fill_r[2:0]]));
    echo_m = echo_ok_nxt && (fill_inc >= atrlf_pkg::FILL_W'(atrlf_pkg::ECHO_LEN));
    scan_m = scan_ok_nxt && (fill_inc >= atrlf_pkg::FILL_W'(atrlf_pkg::SCAN_LEN));

    scan_cnt_nxt = scan_cnt_r;
    if (echo_m) begin
      scan_cnt_nxt = '0;
    end else if (scan_m && (scan_cnt_r != 8'hff)) begin
      scan_cnt_nxt = scan_cnt_r + 8'd1;
    end
    drop = scan_m && (scan_cnt_nxt > max_lines_r);

    priority if (ignore) begin
      fill_nxt = fill_r;
    end else if (early_lf || complete ||
                 (fill_inc >= atrlf_pkg::FILL_W'(atrlf_pkg::LINE_MAX))) begin
      fill_nxt = '0;
    end else begin
      fill_nxt = fill_inc;
    end

    dec.store   = store;
    dec.forward = complete && !drop;
    dec.addr    = fill_r[atrlf_pkg::ADDR_W-1:0];
    dec.len     = fill_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      scan_cnt_r  <= '0;
      max_lines_r <= 8'd8;
      echo_ok_r   <= 1'b0;
      scan_ok_r   <= 1'b0;
      prev_cr_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_lines_r <= cfg_wdata;
      end
      if (take) begin
        fill_r <= fill_nxt;
        if (store) begin
          echo_ok_r <= echo_ok_nxt;
          scan_ok_r <= scan_ok_nxt;
          prev_cr_r <= (rx_byte == atrlf_pkg::CHAR_CR);
        end
        if (complete) begin
          scan_cnt_r <= scan_cnt_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/at_response_line_framer.sv
// A word that completes a forwarded line starts the sequencer: ST_FETCH reads a
// word from the line store into rd_data_r, then ST_SHOW holds it until out_ch.ready
// is high; this repeats for each line word, and no input is taken meanwhile.
// Words that complete no forwarded line are taken one per cycle while in ST_IDLE.
// Synchronous active-low reset clears fill count, scan count and the sequencer;
// max_lines_r returns to 8. The line store is not cleared.
`default_nettype none
module at_response_line_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  atrlf_in_if.sink         in_ch,
  atrlf_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_SHOW} state_t;

  state_t                        state_r;
  logic [atrlf_pkg::ADDR_W-1:0]  idx_r;
  logic [atrlf_pkg::FILL_W-1:0]  len_r;
  logic [7:0]                    rd_data_r;
  logic [7:0]                    line_mem [atrlf_pkg::LINE_MAX];
  logic                          take, is_last;
  atrlf_pkg::decision_t          dec;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign take        = in_ch.valid && in_ch.ready;
  assign is_last     = ({1'b0, idx_r} == (len_r - atrlf_pkg::FILL_W'(1)));

  assign out_ch.valid     = (state_r == ST_SHOW);
  assign out_ch.line_byte = rd_data_r;
  assign out_ch.line_last = is_last;

  atrlf_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rx_byte  (in_ch.rx_byte),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .dec      (dec)
  );

  always_ff @(posedge clk) begin
    if (take && dec.store) begin
      line_mem[dec.addr] <= in_ch.rx_byte;
    end
    if (state_r == ST_FETCH) begin
      rd_data_r <= line_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (take && dec.forward) begin
            idx_r   <= '0;
            len_r   <= dec.len;
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state_r <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_ch.ready) begin
            if (is_last) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + atrlf_pkg::ADDR_W'(1);
              state_r <= ST_FETCH;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: dv/at_response_line_framer_tb.sv
`default_nettype none
module at_response_line_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  atrlf_in_if  in_ch ();
  atrlf_out_if out_ch ();

  at_response_line_framer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Framer state mirrored by the testbench.
  logic [7:0]                   line_buf [atrlf_pkg::LINE_MAX];
  logic [atrlf_pkg::FILL_W-1:0] held = '0;
  logic [7:0]                   scan_seen = '0;
  logic [7:0]                   ap_limit = 8'd8;
  line_word_t                   outgoing_words [$];

  int errors = 0;
  int fed = 0;
  int hold_off = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit line_has_prefix(input bit echo);
    int n;
    logic [7:0] want;
    n = echo ? atrlf_pkg::ECHO_LEN : atrlf_pkg::SCAN_LEN;
    if (held < n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (echo) want = atrlf_pkg::ECHO_PREFIX[i];
      else want = atrlf_pkg::SCAN_PREFIX[i];
      if (line_buf[i] != want) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Updates the mirrored framer with one received byte and queues the words of
  // any line it forwards. Returns 1 when the byte is dropped as a leading NUL.
  function automatic bit frame_byte(input logic [7:0] b);
    bit scan_line;
    if (held == 0 && b == atrlf_pkg::CHAR_NUL) return 1'b1;
    if (b == atrlf_pkg::CHAR_LF && held < 2) begin
      held = '0;
      return 1'b0;
    end
    line_buf[held[atrlf_pkg::ADDR_W-1:0]] = b;
    held = held + 1'b1;
    if (held >= 2 && b == atrlf_pkg::CHAR_LF && line_buf[held - 2] == atrlf_pkg::CHAR_CR) begin
      scan_line = line_has_prefix(1'b0);
      if (line_has_prefix(1'b1)) scan_seen = '0;
      if (scan_line && scan_seen != 8'hff) scan_seen = scan_seen + 1'b1;
      if (!(scan_line && scan_seen > ap_limit)) begin
        for (int i = 0; i < held; i++) begin
          outgoing_words.push_back('{data: line_buf[i], last: (i == held - 1)});
        end
      end
      held = '0;
    end else if (held >= atrlf_pkg::LINE_MAX) begin
      held = '0;
    end
    return 1'b0;
  endfunction

  // Output side: random stall bursts, plus a long hold-off on request.
  initial begin : word_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        stall = hold_off;
        hold_off = 0;
      end else if (stall == 0 && !steady && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : word_check
    line_word_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (outgoing_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual byte %h last %b",
                 $time, out_ch.line_byte, out_ch.line_last);
      end else begin
        want = outgoing_words.pop_front();
        if (out_ch.line_byte !== want.data) begin
          errors++;
          $display("%0t: line_byte mismatch: expected %h, actual %h",
                   $time, want.data, out_ch.line_byte);
        end
        if (out_ch.line_last !== want.last) begin
          errors++;
          $display("%0t: line_last mismatch: expected %b, actual %b",
                   $time, want.last, out_ch.line_last);
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the byte is taken.
  // Valid stays high afterwards so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (!frame_byte(b)) fed++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic end_line();
    send_byte(atrlf_pkg::CHAR_CR);
    send_byte(atrlf_pkg::CHAR_LF);
  endtask

  task automatic send_random_bytes(input int n, input bit printable);
    for (int i = 0; i < n; i++) begin
      if (printable) send_byte(8'($urandom_range(32, 126)));
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Drops valid and waits until every forwarded word has left the block.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (outgoing_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ap_limit(input logic [7:0] v);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ap_limit = v;
  endtask

  task automatic test_plain_lines();
    send_text("OK");
    end_line();
    send_text("A");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'h01);
    end_line();
  endtask

  task automatic test_nul_and_early_lf();
    send_byte(atrlf_pkg::CHAR_NUL);
    send_byte(atrlf_pkg::CHAR_NUL);
    send_byte(atrlf_pkg::CHAR_LF);
    send_text("A");
    send_byte(atrlf_pkg::CHAR_LF);
    end_line();
    // An LF that is not behind a CR is ordinary line content.
    send_text("ab");
    send_byte(atrlf_pkg::CHAR_LF);
    send_text("c");
    end_line();
    send_text("E");
    send_byte(atrlf_pkg::CHAR_CR);
    end_line();
  endtask

  task automatic test_overlong_lines();
    send_random_bytes(atrlf_pkg::LINE_MAX - 2, 1'b1);
    end_line();
    // The CR fills the buffer, so the line is lost and the LF lands on empty.
    repeat (atrlf_pkg::LINE_MAX - 1) send_byte("y");
    end_line();
    send_text("ok");
    end_line();
  endtask

  task automatic test_scan_limit();
    set_ap_limit(8'd2);
    send_text("AT+CWLAP");
    end_line();
    repeat (4) begin
      send_text("+CWLAP:(3)");
      end_line();
    end
    send_text("+CWLAP");
    end_line();
    send_text("AT+CWLA");
    end_line();
    send_text("+CWLAP:");
    end_line();
    send_text("xAT+CWLAP");
    end_line();
    send_text("AT+CWLAP=\"net\"");
    end_line();
    send_text("+CWLAP:(4)");
    end_line();
    set_ap_limit(8'd0);
    send_text("+CWLAP:(0)");
    end_line();
    send_text("AT+CWLAP");
    end_line();
    send_text("+CWLAP:(1)");
    end_line();
    set_ap_limit(8'd8);
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_off = 400;
    repeat (2) begin
      send_random_bytes(30, 1'b1);
      end_line();
    end
    steady = 1'b0;
  endtask

  task automatic send_random_line();
    case ($urandom_range(0, 19))
      0, 1: begin
        send_text("AT+CWLAP");
        send_random_bytes($urandom_range(0, 4), 1'b1);
        end_line();
      end
      2, 3, 4, 5, 6, 7: begin
        send_text("+CWLAP:");
        send_random_bytes($urandom_range(0, 12), 1'b1);
        end_line();
      end
      8, 9, 10, 11, 12, 13, 14: begin
        send_random_bytes($urandom_range(0, 20), 1'($urandom_range(0, 1)));
        end_line();
      end
      15: begin
        send_random_bytes($urandom_range(40, 70), 1'b0);
        if ($urandom_range(0, 1) == 1) end_line();
      end
      16: begin
        if ($urandom_range(0, 1) == 1) send_text("+CWL");
        else send_text("AT+C");
        send_random_bytes($urandom_range(0, 5), 1'b0);
        end_line();
      end
      default: send_random_bytes($urandom_range(1, 6), 1'b0);
    endcase
  endtask

  task automatic test_random_traffic();
    int next_cfg;
    int stop_at;
    next_cfg = fed + 20;
    stop_at = fed + 60;
    while (fed < stop_at) begin
      if (fed >= next_cfg && !steady) begin
        case ($urandom_range(0, 4))
          0: set_ap_limit(8'd0);
          1: set_ap_limit(8'hff);
          2: set_ap_limit(8'd1);
          default: set_ap_limit(8'($urandom_range(0, 12)));
        endcase
        next_cfg = fed + $urandom_range(50, 90);
      end
      // The tail of the run goes without idling on either side.
      if (stop_at - fed < 20) steady = 1'b1;
      send_random_line();
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_lines();
    test_nul_and_early_lf();
    test_overlong_lines();
    test_scan_limit();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
